/* rtl/core/quadrant_color_vote_core_defines.svh */
// ----------------------------------------------------------------------------
// quadrant_color_vote_core_defines
// Assertion macros shared by the quadrant color vote RTL.
// ----------------------------------------------------------------------------
`ifndef QUADRANT_COLOR_VOTE_CORE_DEFINES_SVH
`define QUADRANT_COLOR_VOTE_CORE_DEFINES_SVH

// Clocked property check, off while reset is asserted.
`define QCV_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen at a clock edge.
`define QCV_ASSERT_NEVER(name, cond, msg) \
  `QCV_ASSERT(name, !(cond), msg)

`endif

/* rtl/core/qcv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcv_pkg
// Types, constants and pixel/vote functions of the quadrant color vote core.
// ----------------------------------------------------------------------------
package qcv_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;
  localparam int NUM_CLASSES    = 4;
  localparam int NUM_QUADS      = 4;
  localparam int NUM_ENTRIES    = NUM_CLASSES * NUM_QUADS;
  localparam int VOTE_W         = 17;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 17;

  localparam logic [7:0] RED_MASK   = 8'hF8;
  localparam logic [7:0] GREEN_MASK = 8'hFC;

  typedef logic [VOTE_W-1:0] vote_t;
  typedef vote_t [NUM_ENTRIES-1:0] vote_bank_t;

  typedef enum logic [2:0] {
    CLS_NONE   = 3'd0,
    CLS_RED    = 3'd1,
    CLS_BLUE   = 3'd2,
    CLS_YELLOW = 3'd3,
    CLS_GREEN  = 3'd4
  } class_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH      = 3'd0,
    REG_FRAME_HEIGHT     = 3'd1,
    REG_HIGH_LEVEL       = 3'd2,
    REG_LOW_LEVEL        = 3'd3,
    REG_GREEN_BLUE_LIMIT = 3'd4,
    REG_VOTE_THRESHOLD   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [9:0]  frame_width;
    logic [9:0]  frame_height;
    logic [7:0]  high_level;
    logic [7:0]  low_level;
    logic [7:0]  green_blue_limit;
    vote_t       vote_threshold;
  } cfg_t;

  // Pixel in flight between the front register and the vote bank.
  typedef struct packed {
    logic [15:0] pixel;
    logic        eof;
    logic [1:0]  quad;   // 0 TL, 1 TR, 2 BL, 3 BR
  } item_t;

  // First match wins: red, blue, yellow, green.
  function automatic class_e classify(input logic [15:0] px, input logic [7:0] hi,
                                      input logic [7:0] lo, input logic [7:0] gb);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    class_e     cls;
    r = px[15:8] & RED_MASK;
    g = px[10:3] & GREEN_MASK;
    b = {px[4:0], 3'b000};
    if (r > hi && g < lo && b < lo) begin
      cls = CLS_RED;
    end else if (b > hi && r < lo && g < lo) begin
      cls = CLS_BLUE;
    end else if (r > hi && g > hi && b < lo) begin
      cls = CLS_YELLOW;
    end else if (g > hi && r < lo && b < gb) begin
      cls = CLS_GREEN;
    end else begin
      cls = CLS_NONE;
    end
    return cls;
  endfunction

  // Highest count above threshold; ties keep the lower class.
  function automatic class_e winner(input vote_bank_t bank, input logic [1:0] quad,
                                    input vote_t thr);
    vote_t  best;
    vote_t  v;
    class_e win;
    best = '0;
    win  = CLS_NONE;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      v = bank[{quad, 2'(c)}];
      if (v > best && v > thr) begin
        best = v;
        win  = class_e'(3'(c + 1));
      end
    end
    return win;
  endfunction

endpackage

/* rtl/core/quadrant_color_vote_core.sv */
`timescale 1ns / 1ps
// Path: end-of-frame pixel, input register, snapshot, result register, output.
// Throughput: one pixel per cycle, set by the vote bank taking one update per pixel;
//   the pixel input only stalls when an end-of-frame pixel meets a full
//   snapshot, i.e. one result is held at a stalled output and one more waits.
// Reset: async active low; clears position counters, vote counters, valid
//   flags and loads the register defaults (160x120, 150/100/150, 200).
// ----------------------------------------------------------------------------
// quadrant_color_vote_core
// Classifies RGB565 pixels into red/blue/yellow/green, counts votes per frame
// quadrant and reports the winning class of each quadrant at end of frame.
// ----------------------------------------------------------------------------
`include "quadrant_color_vote_core_defines.svh"

module quadrant_color_vote_core import qcv_pkg::*; #(
  parameter int MaxWidth  = MAX_WIDTH_DEF,
  parameter int MaxHeight = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // pixel channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [15:0]           pixel_i,
  input  logic                  end_of_frame_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            top_left_o,
  output logic [2:0]            top_right_o,
  output logic [2:0]            bottom_left_o,
  output logic [2:0]            bottom_right_o
);

  cfg_t       cfg_q, cfg_d;
  logic       a_valid;
  item_t      a_item;
  logic       a_adv;
  logic       snap_valid;
  logic       snap_take;
  vote_bank_t snap;

  // --------------------------------------------------------------------------
  // Register file. Writes are expected only while the pipeline is drained;
  // unknown indexes are dropped.
  // --------------------------------------------------------------------------
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_FRAME_WIDTH:      cfg_d.frame_width      = cfg_wdata_i[9:0];
        REG_FRAME_HEIGHT:     cfg_d.frame_height     = cfg_wdata_i[9:0];
        REG_HIGH_LEVEL:       cfg_d.high_level       = cfg_wdata_i[7:0];
        REG_LOW_LEVEL:        cfg_d.low_level        = cfg_wdata_i[7:0];
        REG_GREEN_BLUE_LIMIT: cfg_d.green_blue_limit = cfg_wdata_i[7:0];
        REG_VOTE_THRESHOLD:   cfg_d.vote_threshold   = cfg_wdata_i[VOTE_W-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{frame_width:      10'd160,
                 frame_height:     10'd120,
                 high_level:       8'd150,
                 low_level:        8'd100,
                 green_blue_limit: 8'd150,
                 vote_threshold:   VOTE_W'(200)};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: input register. The quadrant is resolved here from the raster
  // counters so the counters can advance on every transfer.
  // --------------------------------------------------------------------------
  qcv_front #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_i        (pixel_i),
    .end_of_frame_i (end_of_frame_i),
    .frame_width_i  (cfg_q.frame_width),
    .frame_height_i (cfg_q.frame_height),
    .adv_i          (a_adv),
    .valid_o        (a_valid),
    .item_o         (a_item)
  );

  // --------------------------------------------------------------------------
  // Stage B: classify and bump one of 16 saturating counters. The end-of-frame
  // pixel is counted, the bank is copied into a snapshot and cleared at once,
  // so the next frame can start in the following cycle. Only an end-of-frame
  // pixel waits, and only while the previous snapshot is still unclaimed.
  // --------------------------------------------------------------------------
  qcv_votes u_votes (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (a_valid),
    .item_i             (a_item),
    .high_level_i       (cfg_q.high_level),
    .low_level_i        (cfg_q.low_level),
    .green_blue_limit_i (cfg_q.green_blue_limit),
    .snap_take_i        (snap_take),
    .adv_o              (a_adv),
    .snap_valid_o       (snap_valid),
    .snap_o             (snap)
  );

  // --------------------------------------------------------------------------
  // Stage C: four-way winner per quadrant into the result register.
  // --------------------------------------------------------------------------
  qcv_judge u_judge (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .snap_valid_i     (snap_valid),
    .snap_i           (snap),
    .vote_threshold_i (cfg_q.vote_threshold),
    .snap_take_o      (snap_take),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .top_left_o       (top_left_o),
    .top_right_o      (top_right_o),
    .bottom_left_o    (bottom_left_o),
    .bottom_right_o   (bottom_right_o)
  );

  // input side only backs up behind a held end-of-frame pixel
  `QCV_ASSERT_NEVER(a_stall_only_eof, in_stall_o && !(a_valid && a_item.eof), "stall without eof")
  // end of frame always lands in the snapshot
  `QCV_ASSERT(a_eof_snapshot, (a_adv && a_item.eof) |=> snap_valid, "eof lost before snapshot")
  // claimed snapshot always shows up as a result
  `QCV_ASSERT(a_snap_to_out, (snap_valid && snap_take) |=> out_valid_o, "snapshot not presented")

endmodule

/* rtl/core/qcv_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcv_front
// Input register with raster position counters and quadrant lookup.
// ----------------------------------------------------------------------------
module qcv_front import qcv_pkg::*; #(
  parameter int MaxWidth  = MAX_WIDTH_DEF,
  parameter int MaxHeight = MAX_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] pixel_i,
  input  logic        end_of_frame_i,
  input  logic [9:0]  frame_width_i,
  input  logic [9:0]  frame_height_i,
  input  logic        adv_i,
  output logic        valid_o,
  output item_t       item_o
);

  localparam int WBits = $clog2(MaxWidth + 1);
  localparam int HBits = $clog2(MaxHeight + 1);
  localparam int DimWW = (WBits > 10) ? WBits : 10;
  localparam int DimHW = (HBits > 10) ? HBits : 10;
  localparam int ColW  = (MaxWidth > 2) ? $clog2(MaxWidth) : 1;
  localparam int RowW  = (MaxHeight > 2) ? $clog2(MaxHeight) : 1;

  logic [ColW-1:0]  column_q, column_d;
  logic [RowW-1:0]  row_q, row_d;
  logic             valid_q, valid_d;
  item_t            item_q;
  logic [DimWW-1:0] w_raw, w_eff;
  logic [DimHW-1:0] h_raw, h_eff;
  logic [1:0]       quad;
  logic             accept;

  assign in_stall_o = valid_q && !adv_i;
  assign accept     = in_valid_i && !in_stall_o;

  // clamp dims to 1..max
  always_comb begin
    w_raw = DimWW'(frame_width_i);
    h_raw = DimHW'(frame_height_i);
    if (w_raw == '0) begin
      w_eff = DimWW'(1);
    end else if (w_raw > DimWW'(MaxWidth)) begin
      w_eff = DimWW'(MaxWidth);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw == '0) begin
      h_eff = DimHW'(1);
    end else if (h_raw > DimHW'(MaxHeight)) begin
      h_eff = DimHW'(MaxHeight);
    end else begin
      h_eff = h_raw;
    end
  end

  always_comb begin
    quad[1] = !(DimHW'(row_q) < (h_eff >> 1));
    quad[0] = DimWW'(column_q) >= (w_eff >> 1);
  end

  always_comb begin
    column_d = column_q;
    row_d    = row_q;
    valid_d  = valid_q;
    if (adv_i) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d = 1'b1;
      if (end_of_frame_i) begin
        column_d = '0;
        row_d    = '0;
      end else if (DimWW'(column_q) + DimWW'(1) >= w_eff) begin
        column_d = '0;
        if (row_q != RowW'(MaxHeight - 1)) begin
          row_d = row_q + RowW'(1);
        end
      end else begin
        column_d = column_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      row_q    <= '0;
      valid_q  <= 1'b0;
    end else begin
      column_q <= column_d;
      row_q    <= row_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{pixel: pixel_i, eof: end_of_frame_i, quad: quad};
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* rtl/core/qcv_votes.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcv_votes
// Pixel classifier and saturating per-quadrant vote counters; frame snapshot.
// ----------------------------------------------------------------------------
module qcv_votes import qcv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  item_t      item_i,
  input  logic [7:0] high_level_i,
  input  logic [7:0] low_level_i,
  input  logic [7:0] green_blue_limit_i,
  input  logic       snap_take_i,
  output logic       adv_o,
  output logic       snap_valid_o,
  output vote_bank_t snap_o
);

  vote_bank_t       counts_q, counts_d, counts_inc;
  vote_bank_t       snap_q;
  logic             snap_valid_q, snap_valid_d;
  class_e           cls;
  logic [3:0]       hit_idx;
  logic             snap_free;

  assign cls       = classify(item_i.pixel, high_level_i, low_level_i, green_blue_limit_i);
  assign hit_idx   = {item_i.quad, 2'(cls - CLS_RED)};
  assign snap_free = !snap_valid_q || snap_take_i;
  assign adv_o     = valid_i && (!item_i.eof || snap_free);

  always_comb begin
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      counts_inc[e] = counts_q[e];
      if (cls != CLS_NONE && hit_idx == 4'(e) && counts_q[e] != '1) begin
        counts_inc[e] = counts_q[e] + VOTE_W'(1);
      end
    end
    counts_d = counts_q;
    if (adv_o) begin
      counts_d = item_i.eof ? '0 : counts_inc;
    end
  end

  always_comb begin
    snap_valid_d = snap_valid_q;
    if (snap_take_i) begin
      snap_valid_d = 1'b0;
    end
    if (adv_o && item_i.eof) begin
      snap_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counts_q     <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      counts_q     <= counts_d;
      snap_valid_q <= snap_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && item_i.eof) begin
      snap_q <= counts_inc;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule

/* rtl/core/qcv_judge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcv_judge
// Per-quadrant winner selection into the result register.
// ----------------------------------------------------------------------------
module qcv_judge import qcv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       snap_valid_i,
  input  vote_bank_t snap_i,
  input  vote_t      vote_threshold_i,
  output logic       snap_take_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] top_left_o,
  output logic [2:0] top_right_o,
  output logic [2:0] bottom_left_o,
  output logic [2:0] bottom_right_o
);

  logic   out_valid_q, out_valid_d;
  logic   load;
  class_e win_q [NUM_QUADS];

  assign snap_take_o = snap_valid_i && (!out_valid_q || !out_stall_i);
  assign load        = snap_take_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int q = 0; q < NUM_QUADS; q++) begin
        win_q[q] <= winner(snap_i, 2'(q), vote_threshold_i);
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign top_left_o     = win_q[0];
  assign top_right_o    = win_q[1];
  assign bottom_left_o  = win_q[2];
  assign bottom_right_o = win_q[3];

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quadrant color vote core. A local model tracks
// position, quadrant vote counts and register values per pixel transfer and
// queues the expected per-quadrant winners at each end of frame. A checker
// compares every frame result with the oldest queued one. Stimulus runs
// directed frames, random register settings with random frames, output
// hold-off, and row counter saturation.
// ----------------------------------------------------------------------------
module tb_top;
  import qcv_pkg::*;

  localparam int     CLK_HALF_NS   = 2;
  localparam int     RESET_CYCLES  = 4;
  // pixels without end of frame leave no trace, so wait this long after the
  // last transfer before touching registers
  localparam int     DRAIN_CYCLES  = 8;
  localparam int     HOLD_CYCLES   = 150;
  localparam int     RANDOM_PHASES = 8;
  localparam int     PHASE_PIXELS  = 60;
  localparam int     MAX_FRAME_LEN = 40;
  localparam longint TIMEOUT_NS    = 4_000_000;

  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam logic [15:0] PX_BLACK  = 16'h0000;
  localparam logic [15:0] PX_WHITE  = 16'hFFFF;
  localparam logic [15:0] PX_RED    = 16'hF800;
  localparam logic [15:0] PX_BLUE   = 16'h001F;
  localparam logic [15:0] PX_YELLOW = 16'hFFE0;
  localparam logic [15:0] PX_GREEN  = 16'h07E0;

  // index 0 top left, 1 top right, 2 bottom left, 3 bottom right
  typedef logic [NUM_QUADS-1:0][2:0] quad_result_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i    = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [15:0]           pixel_i        = '0;
  logic                  end_of_frame_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [2:0]            top_left_o;
  logic [2:0]            top_right_o;
  logic [2:0]            bottom_left_o;
  logic [2:0]            bottom_right_o;

  quadrant_color_vote_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_i        (pixel_i),
    .end_of_frame_i (end_of_frame_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .top_left_o     (top_left_o),
    .top_right_o    (top_right_o),
    .bottom_left_o  (bottom_left_o),
    .bottom_right_o (bottom_right_o)
  );

  always begin
    #CLK_HALF_NS clk_i = 1'b1;
    #CLK_HALF_NS clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  bit tx_idle_en = 1'b1;   // sender may insert gaps
  bit rx_idle_en = 1'b1;   // receiver may stall
  bit hold_req   = 1'b0;   // ask the receiver for one long hold-off

  int error_count    = 0;
  int pixels_sent    = 0;
  int frames_checked = 0;
  int reg_writes     = 0;

  string quad_name [NUM_QUADS] = '{"top_left", "top_right", "bottom_left", "bottom_right"};

  // model copy of registers and counters
  logic [9:0]  cfg_width;
  logic [9:0]  cfg_height;
  logic [7:0]  cfg_high;
  logic [7:0]  cfg_low;
  logic [7:0]  cfg_gb_limit;
  vote_t       cfg_threshold;
  int unsigned col_pos;
  int unsigned row_pos;
  vote_t       vote_count [NUM_ENTRIES];

  quad_result_t expected_votes [$];   // one entry per end-of-frame transfer
  quad_result_t observed_votes;
  quad_result_t wanted_votes;

  assign observed_votes = {bottom_right_o, bottom_left_o, top_right_o, top_left_o};

  // --------------------------------------------------------------------------
  // Vote model
  // --------------------------------------------------------------------------
  function automatic void reset_model();
    cfg_width     = 10'd160;
    cfg_height    = 10'd120;
    cfg_high      = 8'd150;
    cfg_low       = 8'd100;
    cfg_gb_limit  = 8'd150;
    cfg_threshold = 17'd200;
    col_pos       = 0;
    row_pos       = 0;
    foreach (vote_count[i]) vote_count[i] = '0;
  endfunction

  // 0 acts as 1, anything past the maximum is cut back to it
  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned top);
    if (v < 1) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // channels expand with zero low bits; first match in red, blue, yellow,
  // green order wins
  function automatic class_e pixel_class(input logic [15:0] px);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = {px[15:11], 3'b000};
    g = {px[10:5], 2'b00};
    b = {px[4:0], 3'b000};
    if (r > cfg_high && g < cfg_low && b < cfg_low) return CLS_RED;
    if (b > cfg_high && r < cfg_low && g < cfg_low) return CLS_BLUE;
    if (r > cfg_high && g > cfg_high && b < cfg_low) return CLS_YELLOW;
    if (g > cfg_high && r < cfg_low && b < cfg_gb_limit) return CLS_GREEN;
    return CLS_NONE;
  endfunction

  // strictly greater than both threshold and best so far: ties keep the lower class
  function automatic class_e quad_winner(input int q);
    vote_t  best;
    class_e win;
    best = '0;
    win  = CLS_NONE;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (vote_count[q*NUM_CLASSES+c] > best && vote_count[q*NUM_CLASSES+c] > cfg_threshold) begin
        best = vote_count[q*NUM_CLASSES+c];
        win  = class_e'(3'(c + 1));
      end
    end
    return win;
  endfunction

  // advance the model by one accepted pixel transfer
  function automatic void predict_pixel(input logic [15:0] px, input logic eof);
    int unsigned  w;
    int unsigned  h;
    int           q;
    int           idx;
    class_e       cls;
    quad_result_t res;
    w   = clamp_dim(cfg_width, MAX_WIDTH_DEF);
    h   = clamp_dim(cfg_height, MAX_HEIGHT_DEF);
    cls = pixel_class(px);
    if (cls != CLS_NONE) begin
      q = (row_pos < h / 2) ? 0 : 2;
      if (col_pos >= w / 2) q++;
      idx = q * NUM_CLASSES + int'(cls) - 1;
      if (vote_count[idx] != '1) vote_count[idx]++;   // saturate
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos < MAX_HEIGHT_DEF - 1) row_pos++;    // extra lines stay at the bottom
    end else begin
      col_pos++;
    end
    if (eof) begin
      for (int i = 0; i < NUM_QUADS; i++) res[i] = quad_winner(i);
      expected_votes.push_back(res);
      foreach (vote_count[i]) vote_count[i] = '0;
      col_pos = 0;
      row_pos = 0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // result transfer: out_valid_o high, out_stall_i low at the edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_votes.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no frame pending", frames_checked));
      end else begin
        wanted_votes = expected_votes.pop_front();
        for (int q = 0; q < NUM_QUADS; q++) begin
          if (observed_votes[q] !== wanted_votes[q]) begin
            report_mismatch($sformatf("frame %0d %s: got %0d, expected %0d", frames_checked,
                                      quad_name[q], observed_votes[q], wanted_votes[q]));
          end
        end
      end
      frames_checked++;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender and register helpers
  // --------------------------------------------------------------------------
  // Offer one pixel, hold it until the transfer, then update the model.
  // Valid stays high on return so back-to-back pixels need no extra edge.
  task automatic send_pixel(input logic [15:0] px, input logic eof);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    pixel_i        <= px;
    end_of_frame_i <= eof;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    predict_pixel(px, eof);
    pixels_sent++;
  endtask

  // channel value biased toward strong or weak bands
  function automatic int unsigned rand_channel(input int bits);
    int unsigned top;
    top = (1 << bits) - 1;
    case ($urandom_range(0, 2))
      0:       return $urandom_range(0, top);
      1:       return $urandom_range(top * 5 / 8, top);
      default: return $urandom_range(0, top * 3 / 8);
    endcase
  endfunction

  function automatic logic [15:0] rand_pixel();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return {5'(rand_channel(5)), 6'(rand_channel(6)), 5'(rand_channel(5))};
  endfunction

  // len random pixels; the last one closes the frame when close is set
  task automatic send_frame(input int len, input logic close);
    for (int i = 0; i < len; i++) send_pixel(rand_pixel(), close && (i == len - 1));
  endtask

  // Stop offering, wait for every pending frame result, then for the pipe.
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (expected_votes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // one write, then a wait with the enable low, so the enable never toggles within a step
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= CFG_DATA_W'(value);
    @(posedge clk_i);
    case (idx)
      REG_FRAME_WIDTH:      cfg_width     = 10'(value);
      REG_FRAME_HEIGHT:     cfg_height    = 10'(value);
      REG_HIGH_LEVEL:       cfg_high      = 8'(value);
      REG_LOW_LEVEL:        cfg_low       = 8'(value);
      REG_GREEN_BLUE_LIMIT: cfg_gb_limit  = 8'(value);
      REG_VOTE_THRESHOLD:   cfg_threshold = 17'(value);
      default: ;  // spare index, ignored
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
  endtask

  function automatic int unsigned rand_dim();
    case ($urandom_range(0, 11))
      0:       return 0;
      1:       return 512;
      2:       return 1023;
      3:       return $urandom_range(0, 1023);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  function automatic int unsigned rand_level(input int unsigned center);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 255;
      2:       return $urandom_range(0, 255);
      default: return $urandom_range(center - 40, center + 40);
    endcase
  endfunction

  function automatic int unsigned rand_threshold();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 65536;
      2:       return $urandom_range(0, 65536);
      default: return $urandom_range(0, 6);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // reset values: 160x120 frame, everything in the top left, threshold 200
  task automatic test_reset_defaults();
    send_pixel(PX_BLACK, 1'b0);
    send_pixel(PX_WHITE, 1'b0);
    send_pixel(PX_RED, 1'b0);
    send_pixel(PX_BLUE, 1'b0);
    send_pixel(PX_YELLOW, 1'b0);
    send_pixel(PX_GREEN, 1'b1);
  endtask

  // 4x2 frame, one class per quadrant, threshold 0
  task automatic test_each_class();
    drain_pipeline();
    write_reg(REG_FRAME_WIDTH, 4);
    write_reg(REG_FRAME_HEIGHT, 2);
    write_reg(REG_VOTE_THRESHOLD, 0);
    send_pixel(PX_RED, 1'b0);
    send_pixel(PX_RED, 1'b0);
    send_pixel(PX_BLUE, 1'b0);
    send_pixel(PX_BLUE, 1'b0);
    send_pixel(PX_YELLOW, 1'b0);
    send_pixel(PX_YELLOW, 1'b0);
    send_pixel(PX_GREEN, 1'b0);
    send_pixel(PX_GREEN, 1'b1);
  endtask

  // height 1 puts every line in the bottom half; equal counts go to the lower class
  task automatic test_tie_break();
    drain_pipeline();
    write_reg(REG_FRAME_WIDTH, 2);
    write_reg(REG_FRAME_HEIGHT, 1);
    send_pixel(PX_RED, 1'b0);
    send_pixel(PX_BLUE, 1'b0);
    send_pixel(PX_BLUE, 1'b0);
    send_pixel(PX_RED, 1'b1);
  endtask

  // writes to unused indexes must leave every register alone
  task automatic test_spare_index();
    drain_pipeline();
    write_reg(REG_SPARE_6, 17'h1FFFF);
    write_reg(REG_SPARE_7, 17'h1FFFF);
    send_pixel(PX_RED, 1'b0);
    send_pixel(PX_BLUE, 1'b1);
  endtask

  // registers change while a frame is open; new values apply from the next pixel
  task automatic test_midframe_config();
    drain_pipeline();
    write_reg(REG_FRAME_WIDTH, 4);
    write_reg(REG_FRAME_HEIGHT, 4);
    send_pixel(PX_RED, 1'b0);
    send_pixel(PX_RED, 1'b0);
    send_pixel(PX_RED, 1'b0);
    drain_pipeline();
    write_reg(REG_FRAME_WIDTH, 2);
    write_reg(REG_HIGH_LEVEL, 200);
    send_pixel(PX_BLUE, 1'b0);
    send_pixel(PX_GREEN, 1'b0);
    send_pixel(PX_RED, 1'b0);
    send_pixel(PX_YELLOW, 1'b1);
  endtask

  // receiver holds off while short frames keep coming, so results back up
  // and the core has to stall its pixel input
  task automatic test_output_backpressure();
    drain_pipeline();
    write_reg(REG_FRAME_WIDTH, 2);
    write_reg(REG_FRAME_HEIGHT, 2);
    write_reg(REG_HIGH_LEVEL, 150);
    write_reg(REG_VOTE_THRESHOLD, 0);
    hold_req = 1'b1;
    repeat (12) send_frame(3, 1'b1);
  endtask

  // Each phase: fresh random registers, then mostly whole frames of the
  // configured size with random content, some of random length; sometimes a
  // frame is left open across the next register update.
  task automatic test_random_frames(input int phases);
    int unsigned area;
    int unsigned len;
    int unsigned sent;
    for (int p = 0; p < phases; p++) begin
      drain_pipeline();
      write_reg(REG_FRAME_WIDTH, rand_dim());
      write_reg(REG_FRAME_HEIGHT, rand_dim());
      write_reg(REG_HIGH_LEVEL, rand_level(150));
      write_reg(REG_LOW_LEVEL, rand_level(100));
      write_reg(REG_GREEN_BLUE_LIMIT, rand_level(150));
      write_reg(REG_VOTE_THRESHOLD, rand_threshold());
      area = clamp_dim(cfg_width, MAX_WIDTH_DEF) * clamp_dim(cfg_height, MAX_HEIGHT_DEF);
      sent = 0;
      while (sent < PHASE_PIXELS) begin
        if (area <= MAX_FRAME_LEN && $urandom_range(0, 3) != 0) len = area;
        else len = $urandom_range(1, MAX_FRAME_LEN);
        send_frame(len, 1'b1);
        sent += len;
      end
      if ($urandom_range(0, 2) == 0) send_frame($urandom_range(1, 5), 1'b0);
    end
  endtask

  // width 0 acts as 1, height 1023 clamps to 512: after 512 lines the row
  // stays at the last line, so the red tail must vote bottom right
  task automatic test_row_saturation();
    drain_pipeline();
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 1023);
    write_reg(REG_HIGH_LEVEL, 150);
    write_reg(REG_LOW_LEVEL, 100);
    write_reg(REG_VOTE_THRESHOLD, 10);
    repeat (MAX_HEIGHT_DEF) send_pixel(PX_BLACK, 1'b0);
    repeat (18) send_pixel(PX_RED, 1'b0);
    send_pixel(PX_RED, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    reset_model();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_each_class();
    test_tie_break();
    test_spare_index();
    test_midframe_config();
    test_output_backpressure();
    test_random_frames(RANDOM_PHASES);

    // closing stretch runs at full rate on both sides
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_row_saturation();
    test_random_frames(2);

    drain_pipeline();
    $display("Covered %0d pixel transfers, %0d frame results, %0d register writes.",
             pixels_sent, frames_checked, reg_writes);
    $display("Included reset values, range extremes, tie breaks, hold-off, %s%0d mismatches.",
             "row saturation; ", error_count);
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_top failed");
    $finish;
  end

endmodule
